FILE: rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync, length and CRC deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_PASS    = 3'd2;
    localparam logic [2:0] KIND_FAIL    = 3'd3;
    localparam logic [2:0] KIND_REJECT  = 3'd4;

    localparam logic       CFG_SYNC_WORD = 1'b0;
    localparam logic       CFG_CRC_POLY  = 1'b1;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_TRAILER
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR,
        BK_SHIFT,
        BK_SEARCH
    } back_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [12:0] flen;
        logic [31:0] rcrc;
        logic [31:0] ccrc;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b,
                                             input logic [31:0] poly);
        logic [31:0] c;
        c = crc_in ^ {b, 24'd0};
        for (int i = 0; i < 8; i++) begin
            if (c[31])
            begin
                c = {c[30:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/sync_length_crc_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_crc_deframer
// Byte stream deframer with sync search, length check and 32-bit CRC check.
// ----------------------------------------------------------------------------
// Body and trailer bytes are handled as they are accepted. A full header window
// is checked and then its bytes are emitted as a run, or, on a bad sync word or
// a length reject, searched for a later sync word, one offset a cycle; the input
// is stalled meanwhile. Results pass through a four-entry queue.
module sync_length_crc_deframer #(
    parameter int HEADER_BYTES   = 16,
    parameter int MAX_BODY_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic [12:0] frame_length,
    output logic [31:0] received_crc,
    output logic [31:0] computed_crc,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import slcd_pkg::*;

    logic [31:0] sync_reg;
    logic [31:0] poly_reg;
    logic        push;
    logic        full;
    result_t     wdata;
    result_t     rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= '0;
            poly_reg <= 32'h04C1_1DB7;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SYNC_WORD: sync_reg <= cfg_data;
                CFG_CRC_POLY:  poly_reg <= cfg_data;
                default:       sync_reg <= sync_reg;
            endcase
        end
    end

    slcd_core #(
        .HEADER_BYTES   (HEADER_BYTES),
        .MAX_BODY_BYTES (MAX_BODY_BYTES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (data_byte),
        .sync_word      (sync_reg),
        .crc_polynomial (poly_reg),
        .push           (push),
        .wdata          (wdata),
        .full           (full)
    );

    slcd_result_fifo #(
        .DEPTH (4)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .full  (full),
        .valid (out_valid),
        .stall (out_stall),
        .rdata (rdata)
    );

    assign result_kind  = rdata.kind;
    assign out_byte     = rdata.data;
    assign last_of_run  = rdata.last;
    assign frame_length = rdata.flen;
    assign received_crc = rdata.rcrc;
    assign computed_crc = rdata.ccrc;

endmodule

FILE: rtl/slcd_result_fifo.sv
// ----------------------------------------------------------------------------
// slcd_result_fifo
// Small queue of result requests between the deframer core and the output.
// ----------------------------------------------------------------------------
module slcd_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  slcd_pkg::result_t wdata,
    output logic             full,
    output logic             valid,
    input  logic             stall,
    output slcd_pkg::result_t rdata
);
    import slcd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    result_t            mem_reg [DEPTH];
    logic [AW-1:0]      wptr_reg;
    logic [AW-1:0]      rptr_reg;
    logic [AW:0]        count_reg;
    logic               pop;

    assign pop   = valid && !stall;
    assign valid = (count_reg != '0);
    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

FILE: rtl/slcd_core.sv
// ----------------------------------------------------------------------------
// slcd_core
// Front part takes bytes and classifies them; back part emits header runs,
// body and trailer results, and searches the window for a later sync word.
// ----------------------------------------------------------------------------
module slcd_core #(
    parameter int HEADER_BYTES   = 16,
    parameter int MAX_BODY_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic [31:0]       sync_word,
    input  logic [31:0]       crc_polynomial,
    output logic              push,
    output slcd_pkg::result_t wdata,
    input  logic              full
);
    import slcd_pkg::*;

    localparam int WAW = $clog2(HEADER_BYTES);
    localparam int FW  = $clog2(HEADER_BYTES + 1);
    localparam int LW  = $clog2(MAX_BODY_BYTES + 1);
    localparam logic [31:0] MAX_LEN = 32'(MAX_BODY_BYTES);

    logic [7:0]     win_reg [HEADER_BYTES];
    logic [7:0]     win_next [HEADER_BYTES];
    logic [FW-1:0]  fill_reg, fill_next;
    phase_t         phase_reg, phase_next;
    back_state_t    bstate_reg, bstate_next;
    logic [LW-1:0]  left_reg, left_next;
    logic [LW-1:0]  blen_reg, blen_next;
    logic [31:0]    crc_reg, crc_next;
    logic [31:0]    tcrc_reg, tcrc_next;
    logic [WAW-1:0] idx_reg, idx_next;
    logic [FW-1:0]  k_reg, k_next;
    logic           accept;
    logic [31:0]    head_word;
    logic [31:0]    len_word;
    logic [31:0]    k_word;
    logic [31:0]    calc;

    assign head_word = {win_reg[3], win_reg[2], win_reg[1], win_reg[0]};
    assign len_word  = {win_reg[HEADER_BYTES-1], win_reg[HEADER_BYTES-2],
                        win_reg[HEADER_BYTES-3], win_reg[HEADER_BYTES-4]};
    assign k_word    = {win_reg[WAW'(k_reg + 3)], win_reg[WAW'(k_reg + 2)],
                        win_reg[WAW'(k_reg + 1)], win_reg[WAW'(k_reg)]};
    assign calc      = crc_reg ^ CRC_INIT;
    assign in_stall  = (bstate_reg != BK_IDLE) || full;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        bstate_next = bstate_reg;
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        left_next   = left_reg;
        blen_next   = blen_reg;
        crc_next    = crc_reg;
        tcrc_next   = tcrc_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            win_next[i] = win_reg[i];
        end
        push  = 1'b0;
        wdata = '0;
        case (bstate_reg)
            BK_IDLE:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        PH_BODY:
                        begin
                            crc_next   = crc_byte(crc_reg, in_byte, crc_polynomial);
                            push       = 1'b1;
                            wdata.kind = KIND_PAYLOAD;
                            wdata.data = in_byte;
                            wdata.last = 1'b1;
                            wdata.flen = 13'(blen_reg);
                            left_next  = left_reg - 1'b1;
                            if (left_reg == LW'(1))
                            begin
                                phase_next = PH_TRAILER;
                                left_next  = LW'(4);
                                tcrc_next  = '0;
                            end
                        end
                        PH_TRAILER:
                        begin
                            tcrc_next = {in_byte, tcrc_reg[31:8]};
                            left_next = left_reg - 1'b1;
                            if (left_reg == LW'(1))
                            begin
                                push       = 1'b1;
                                wdata.kind = (tcrc_next == calc) ? KIND_PASS : KIND_FAIL;
                                wdata.last = 1'b1;
                                wdata.flen = 13'(blen_reg);
                                wdata.rcrc = tcrc_next;
                                wdata.ccrc = calc;
                                crc_next   = CRC_INIT;
                                phase_next = PH_HEADER;
                                fill_next  = '0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HEADER;
                            win_next[WAW'(fill_reg)] = in_byte;
                            fill_next = fill_reg + 1'b1;
                            if (fill_reg == FW'(HEADER_BYTES - 1))
                            begin
                                k_next      = FW'(1);
                                bstate_next = BK_HDR;
                            end
                        end
                    endcase
                end
            end
            BK_HDR:
            begin
                if (head_word != sync_word)
                begin
                    bstate_next = BK_SEARCH;
                end
                else if (len_word > MAX_LEN)
                begin
                    if (!full)
                    begin
                        push        = 1'b1;
                        wdata.kind  = KIND_REJECT;
                        wdata.last  = 1'b1;
                        wdata.flen  = 13'(MAX_BODY_BYTES);
                        bstate_next = BK_SEARCH;
                    end
                end
                else
                begin
                    blen_next   = LW'(len_word);
                    crc_next    = CRC_INIT;
                    idx_next    = '0;
                    bstate_next = BK_SHIFT;
                end
            end
            BK_SHIFT:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    wdata.kind = KIND_HEADER;
                    wdata.data = win_reg[idx_reg];
                    wdata.flen = 13'(blen_reg);
                    wdata.last = (idx_reg == WAW'(HEADER_BYTES - 1));
                    crc_next   = crc_byte(crc_reg, win_reg[idx_reg], crc_polynomial);
                    idx_next   = idx_reg + 1'b1;
                    if (idx_reg == WAW'(HEADER_BYTES - 1))
                    begin
                        fill_next   = '0;
                        bstate_next = BK_IDLE;
                        if (blen_reg == '0)
                        begin
                            phase_next = PH_TRAILER;
                            left_next  = LW'(4);
                            tcrc_next  = '0;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                            left_next  = blen_reg;
                        end
                    end
                end
            end
            BK_SEARCH:
            begin
                if (k_reg > FW'(HEADER_BYTES - 4))
                begin
                    fill_next   = '0;
                    bstate_next = BK_IDLE;
                end
                else if (k_word == sync_word)
                begin
                    for (int i = 0; i < HEADER_BYTES; i++)
                    begin
                        win_next[i] = win_reg[WAW'(i + int'(k_reg))];
                    end
                    fill_next   = FW'(HEADER_BYTES) - k_reg;
                    bstate_next = BK_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                bstate_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        idx_reg <= idx_next;
        k_reg   <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg <= BK_IDLE;
            phase_reg  <= PH_HEADER;
            fill_reg   <= '0;
            left_reg   <= '0;
            blen_reg   <= '0;
            crc_reg    <= CRC_INIT;
            tcrc_reg   <= '0;
        end
        else
        begin
            bstate_reg <= bstate_next;
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            left_reg   <= left_next;
            blen_reg   <= blen_next;
            crc_reg    <= crc_next;
            tcrc_reg   <= tcrc_next;
        end
    end

endmodule

FILE: test/sync_length_crc_deframer_tb.sv
// ----------------------------------------------------------------------------
// sync_length_crc_deframer_tb
// Drives framed and unframed byte streams into the deframer under random
// input gaps and output stalls, predicts every header, payload, verdict and
// reject result, and checks each one field by field across several settings
// of the sync word and the CRC polynomial.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sync_length_crc_deframer_tb;
    import slcd_pkg::*;

    localparam int HDR_LEN  = 16;
    localparam int MAX_BODY = 4096;
    localparam int SETTLE   = HDR_LEN + 12;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        result_t    want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  result_kind;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [12:0] frame_length;
    logic [31:0] received_crc;
    logic [31:0] computed_crc;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] sync_reg;
    logic [31:0] poly_reg;
    logic [7:0]  window [HDR_LEN];
    int          fill;
    phase_t      phase;
    int          bytes_left;
    logic [12:0] body_len;
    logic [31:0] run_crc;
    logic [31:0] trailer;

    result_t     expected_q[$];
    logic [7:0]  stream_q[$];
    bit          failed;
    bit          quiet;
    int          stall_left;
    int          sent;

    localparam result_t REJECT_RES = '{kind: KIND_REJECT, data: 8'd0, last: 1'b1,
                                       flen: 13'(MAX_BODY), rcrc: 32'd0, ccrc: 32'd0};

    localparam stim_row_t DIRECTED [20] = '{
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h7F, 1'b0, '0},
        '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hFE, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0}, '{8'h10, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, REJECT_RES},
        '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}
    };

    sync_length_crc_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .frame_length (frame_length),
        .received_crc (received_crc),
        .computed_crc (computed_crc),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b,
                                               logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++)
        begin
            c = c[31] ? ({c[30:0], 1'b0} ^ poly) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [31:0] window_word(int pos);
        return {window[pos + 3], window[pos + 2], window[pos + 1], window[pos]};
    endfunction

    function automatic void drop_to_next_sync();
        for (int k = 1; k + 4 <= fill; k++)
        begin
            if (window_word(k) == sync_reg)
            begin
                for (int j = 0; j < fill - k; j++)
                begin
                    window[j] = window[j + k];
                end
                fill = fill - k;
                return;
            end
        end
        fill = 0;
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [7:0] d, logic [12:0] flen,
                                        logic [31:0] rcrc, logic [31:0] ccrc);
        expected_q.insert(expected_q.size(), '{kind: kind, data: d, last: 1'b0, flen: flen,
                                               rcrc: rcrc, ccrc: ccrc});
    endfunction

    // Advances the deframer state by one accepted byte and queues its results.
    function automatic int deframe_byte(logic [7:0] b);
        int          first;
        logic [31:0] len;
        logic [31:0] calc;
        result_t     r;
        first = expected_q.size();
        if (phase == PH_BODY)
        begin
            run_crc = crc_update(run_crc, b, poly_reg);
            push_result(KIND_PAYLOAD, b, body_len, 32'd0, 32'd0);
            if (bytes_left > 0)
            begin
                bytes_left--;
            end
            if (bytes_left == 0)
            begin
                phase = PH_TRAILER;
                bytes_left = 4;
                trailer = 32'd0;
            end
        end
        else if (phase == PH_TRAILER)
        begin
            trailer |= 32'(b) << (8 * ((4 - (bytes_left & 3)) & 3));
            if (bytes_left > 0)
            begin
                bytes_left--;
            end
            if (bytes_left == 0)
            begin
                calc = run_crc ^ CRC_INIT;
                push_result((trailer == calc) ? KIND_PASS : KIND_FAIL, 8'd0, body_len,
                            trailer, calc);
                run_crc = CRC_INIT;
                phase = PH_HEADER;
                fill = 0;
            end
        end
        else
        begin
            phase = PH_HEADER;
            if (fill >= HDR_LEN)
            begin
                fill = 0;
            end
            window[fill] = b;
            fill++;
            if (fill == HDR_LEN)
            begin
                len = window_word(HDR_LEN - 4);
                if (window_word(0) != sync_reg)
                begin
                    drop_to_next_sync();
                end
                else if (len > MAX_BODY)
                begin
                    push_result(KIND_REJECT, 8'd0, 13'(MAX_BODY), 32'd0, 32'd0);
                    drop_to_next_sync();
                end
                else
                begin
                    body_len = len[12:0];
                    run_crc = CRC_INIT;
                    for (int i = 0; i < HDR_LEN; i++)
                    begin
                        run_crc = crc_update(run_crc, window[i], poly_reg);
                        push_result(KIND_HEADER, window[i], body_len, 32'd0, 32'd0);
                    end
                    fill = 0;
                    bytes_left = (len == 0) ? 4 : int'(len);
                    phase = (len == 0) ? PH_TRAILER : PH_BODY;
                    trailer = 32'd0;
                end
            end
        end
        if (expected_q.size() > first)
        begin
            r = expected_q[$];
            r.last = 1'b1;
            expected_q[$] = r;
        end
        return expected_q.size() - first;
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_SYNC_WORD)
        begin
            sync_reg = value;
        end
        else
        begin
            poly_reg = value;
        end
    endtask

    task automatic queue_header(logic [31:0] len);
        for (int i = 0; i < 4; i++)
        begin
            stream_q.insert(stream_q.size(), sync_reg[8 * i +: 8]);
        end
        for (int i = 4; i < HDR_LEN - 4; i++)
        begin
            stream_q.insert(stream_q.size(), 8'($urandom));
        end
        for (int i = 0; i < 4; i++)
        begin
            stream_q.insert(stream_q.size(), len[8 * i +: 8]);
        end
    endtask

    // Queues one random request: a good frame, a corrupted frame, a rejected
    // header, or line noise that forces a sync search.
    task automatic queue_random_request();
        int          pick;
        int          len;
        int          start;
        logic [31:0] crc;
        logic [31:0] big;
        pick = $urandom_range(0, 99);
        start = stream_q.size();
        if (pick < 65)
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
            queue_header(32'(len));
            for (int i = 0; i < len; i++)
            begin
                stream_q.insert(stream_q.size(), 8'($urandom));
            end
            crc = CRC_INIT;
            for (int i = start; i < stream_q.size(); i++)
            begin
                crc = crc_update(crc, stream_q[i], poly_reg);
            end
            crc ^= CRC_INIT;
            if (pick >= 50)
            begin
                crc ^= 32'(1) << $urandom_range(0, 31);
            end
            for (int i = 0; i < 4; i++)
            begin
                stream_q.insert(stream_q.size(), crc[8 * i +: 8]);
            end
        end
        else if (pick < 75)
        begin
            case ($urandom_range(0, 2))
                0: big = 32'(MAX_BODY + 1);
                1: big = 32'hFFFF_FFFF;
                default: big = 32'($urandom_range(MAX_BODY + 1, 32'h7FFF_FFFF));
            endcase
            queue_header(big);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                stream_q.insert(stream_q.size(), ($urandom_range(0, 2) == 0) ?
                                sync_reg[8 * $urandom_range(0, 3) +: 8] : 8'($urandom));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d byte %02h", result_kind, out_byte);
                    failed = 1'b1;
                end
                else
                begin
                    result_t w;
                    w = expected_q.pop_front();
                    if (result_kind !== w.kind)
                    begin
                        $error("result_kind: expected %0d, actual %0d", w.kind, result_kind);
                        failed = 1'b1;
                    end
                    if (out_byte !== w.data)
                    begin
                        $error("out_byte: expected %02h, actual %02h", w.data, out_byte);
                        failed = 1'b1;
                    end
                    if (last_of_run !== w.last)
                    begin
                        $error("last_of_run: expected %0d, actual %0d", w.last, last_of_run);
                        failed = 1'b1;
                    end
                    if (frame_length !== w.flen)
                    begin
                        $error("frame_length: expected %0d, actual %0d", w.flen, frame_length);
                        failed = 1'b1;
                    end
                    if (received_crc !== w.rcrc)
                    begin
                        $error("received_crc: expected %08h, actual %08h", w.rcrc, received_crc);
                        failed = 1'b1;
                    end
                    if (computed_crc !== w.ccrc)
                    begin
                        $error("computed_crc: expected %08h, actual %08h", w.ccrc, computed_crc);
                        failed = 1'b1;
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 13);
                out_stall <= (stall_left > 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= (stall_left > 0);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic [31:0] syncs [4];
        logic [31:0] polys [4];
        int          n;
        result_t     junk;
        syncs = '{32'hFFFF_FFFF, 32'($urandom), 32'h0000_0000, 32'($urandom)};
        polys = '{32'h04C1_1DB7, 32'hFFFF_FFFF, 32'h0000_0000, 32'($urandom)};
        failed     = 1'b0;
        quiet      = 1'b0;
        sent       = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'd0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_SYNC_WORD;
        cfg_data   = 32'd0;
        sync_reg   = 32'd0;
        poly_reg   = 32'h04C1_1DB7;
        fill       = 0;
        phase      = PH_HEADER;
        bytes_left = 0;
        body_len   = 13'd0;
        run_crc    = CRC_INIT;
        trailer    = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i].b);
            n = deframe_byte(DIRECTED[i].b);
            if (DIRECTED[i].typed)
            begin
                repeat (n) junk = expected_q.pop_back();
                expected_q.insert(expected_q.size(), DIRECTED[i].want);
            end
        end
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_SYNC_WORD, syncs[p]);
            write_reg(CFG_CRC_POLY, polys[p]);
            while (sent < 20 + 64 * (p + 1))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    quiet = ~quiet;
                end
                queue_random_request();
                while (stream_q.size() != 0)
                begin
                    logic [7:0] b;
                    b = stream_q.pop_front();
                    send_byte(b);
                    n = deframe_byte(b);
                end
                if (p == 1 && sent > 20 + 64 + 30 && sent < 20 + 64 + 60)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_q.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            // Close any half-built frame body or trailer before the next settings.
            while (phase != PH_HEADER)
            begin
                send_byte(8'($urandom));
                n = deframe_byte(data_byte);
            end
            wait_drained();
        end

        if (!failed)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
